// ===== src/blc_pkg.sv =====
// Package for the block linear convolution engine.
// Holds the transaction payload types, the MAC control struct and the FSM states.
// No dependencies.
`timescale 1ns / 1ps

package blc_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 37;
    localparam int TC_W   = 6;
    localparam int IDX_W  = 5;
    localparam int RES_CAP = 32;
    localparam logic [TC_W-1:0] TC_RESET = 6'd32;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] sample_value;
        logic                     block_end;
        logic [IDX_W-1:0]         coef_index;
        logic signed [DATA_W-1:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] conv_value;
        logic                    run_last;
    } t_out;

    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_PUT
    } t_state;

endpackage

// ===== src/blc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the coefficient store; no package dependency.
`timescale 1ns / 1ps

module blc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/blc_mac.sv =====
// Shared multiply-accumulate unit: registered 16x16 product, then 37-bit accumulate.
// Depends on blc_pkg for widths and the control struct.
`timescale 1ns / 1ps

module blc_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  blc_pkg::t_mac_ctl                i_ctl,
    input  logic signed [blc_pkg::DATA_W-1:0] i_coef,
    input  logic signed [blc_pkg::DATA_W-1:0] i_smp,
    output logic signed [blc_pkg::ACC_W-1:0]  o_acc,
    output logic                             o_done
);
    import blc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_pv   <= 1'b0;
            r_pl   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= i_ctl.vld;
            r_pl   <= i_ctl.last;
            r_done <= r_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== src/block_linear_convolution.sv =====
// A sample transaction gives its first result after the single shared MAC has stepped
// through all TAPS delay-line positions; each tail result repeats that walk. New input
// is stalled until the last result is handed to the output register; coefficient loads
// are taken in the idle state and do not stall the input.
// Reset (synchronous, active low) zeroes the delay line, sets tap_count to 32 and
// idles the sequencer; the coefficient store is not cleared.
`timescale 1ns / 1ps

module block_linear_convolution #(
    parameter int TAPS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  blc_pkg::t_in             i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output blc_pkg::t_out            o_data,
    input  logic                     i_cfg_we,
    input  logic [blc_pkg::TC_W-1:0] i_cfg_wdata
);
    import blc_pkg::*;

    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int NMAX = (TAPS < RES_CAP) ? TAPS : RES_CAP;

    t_state r_state, n_state;

    logic [TC_W-1:0]         r_tap_count;
    logic [TC_W-1:0]         r_ntap;
    logic [AW-1:0]           r_cnt;
    logic [IDX_W-1:0]        r_k;
    logic                    r_blk;
    logic signed [DATA_W-1:0] r_dly [TAPS];
    logic signed [DATA_W-1:0] n_dly [TAPS];
    logic signed [DATA_W-1:0] r_smp;
    logic                    r_rv;
    logic                    r_rlast;
    logic                    r_ovld;
    t_out                    r_out;

    logic                    in_acc, is_smp, is_load, put_go, tail_more, run_end;
    logic                    mac_clr;
    logic [TC_W-1:0]         tc_min1, ntap_in;
    logic                    coef_we;
    logic [DATA_W-1:0]       coef_rdata;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;
    t_mac_ctl                mac_ctl;

    // active tap count: zero acts as one, saturate at min(TAPS, 32)
    assign tc_min1 = (r_tap_count == '0) ? TC_W'(1) : r_tap_count;
    assign ntap_in = (tc_min1 > TC_W'(NMAX)) ? TC_W'(NMAX) : tc_min1;

    assign run_end   = (r_cnt == AW'(TAPS - 1));
    assign tail_more = r_blk && ({1'b0, r_k} != (r_ntap - TC_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (is_smp) n_state = ST_RUN;
            ST_RUN:  if (run_end) n_state = ST_WAIT;
            ST_WAIT: if (mac_done) n_state = ST_PUT;
            ST_PUT: begin
                if (put_go) n_state = tail_more ? ST_RUN : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_acc  = 1'b0;
        put_go  = 1'b0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                in_acc  = i_valid;
            end
            ST_PUT:  put_go = !r_ovld || !i_stall;
            default: begin
                in_acc = 1'b0;
            end
        endcase
    end

    assign is_smp  = in_acc && (i_data.op == OP_SAMPLE);
    assign is_load = in_acc && (i_data.op == OP_LOAD);
    assign mac_clr = is_smp || (put_go && tail_more);
    assign coef_we = is_load && ({2'b00, i_data.coef_index} < 7'(TAPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= TC_RESET;
            r_ovld      <= 1'b0;
            r_rv        <= 1'b0;
            r_rlast     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tap_count <= i_cfg_wdata;
            if (put_go) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            r_rv    <= (r_state == ST_RUN) && ({1'b0, 7'(r_cnt)} < {2'b00, r_ntap});
            r_rlast <= (r_state == ST_RUN) && run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_smp) begin
            r_ntap <= ntap_in;
            r_blk  <= i_data.block_end;
            r_k    <= '0;
        end else if (put_go && tail_more) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (is_smp || (put_go && tail_more)) begin
            r_cnt <= '0;
        end else if (r_state == ST_RUN) begin
            r_cnt <= r_cnt + AW'(1);
        end
        r_smp <= r_dly[0];
        if (put_go) begin
            r_out.conv_value <= mac_acc;
            r_out.run_last   <= r_blk && !tail_more;
        end
    end

    // delay line: shift (zero on tail), rotate on tap walk, clear at block end
    always_comb begin
        for (int i = 0; i < TAPS; i++) n_dly[i] = r_dly[i];
        if (is_smp || (put_go && tail_more)) begin
            for (int i = TAPS - 1; i > 0; i--) n_dly[i] = r_dly[i-1];
            n_dly[0] = is_smp ? i_data.sample_value : '0;
        end else if (r_state == ST_RUN) begin
            for (int i = 0; i < TAPS - 1; i++) n_dly[i] = r_dly[i+1];
            n_dly[TAPS-1] = r_dly[0];
        end else if (put_go && r_blk) begin
            for (int i = 0; i < TAPS; i++) n_dly[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TAPS; i++) begin
            r_dly[i] <= i_rst_n ? n_dly[i] : '0;
        end
    end

    blc_ram #(
        .WIDTH(DATA_W),
        .DEPTH(TAPS),
        .AW   (AW)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(AW'(i_data.coef_index)),
        .i_wdata(i_data.coef_value),
        .i_raddr(r_cnt),
        .o_rdata(coef_rdata)
    );

    assign mac_ctl.clr  = mac_clr;
    assign mac_ctl.vld  = r_rv;
    assign mac_ctl.last = r_rlast;

    blc_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mac_ctl),
        .i_coef (signed'(coef_rdata)),
        .i_smp  (r_smp),
        .o_acc  (mac_acc),
        .o_done (mac_done)
    );

    assign o_valid = r_ovld;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == ST_WAIT))
        else $error("MAC done outside wait state");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put_go |=> (o_data.run_last == $past(r_blk && !tail_more)))
        else $error("run_last does not match tail position");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_go && r_blk && !tail_more) |=> (r_dly[0] == '0 && r_dly[TAPS-1] == '0))
        else $error("delay line not cleared after block");

    a_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && $past(r_state) != ST_RUN) |-> (r_cnt == '0))
        else $error("tap walk did not start at zero");
`endif

endmodule

// ===== bench/conv_checker.sv =====
// Result checker for block_linear_convolution: watches the sample, result and tap register
// ports, predicts every convolution output and compares it with what the block delivers.
// Depends on blc_pkg.
`timescale 1ns / 1ps

module conv_checker #(
    parameter int TAPS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  blc_pkg::t_in             i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  blc_pkg::t_out            i_out_data,
    input  logic                     i_cfg_we,
    input  logic [blc_pkg::TC_W-1:0] i_cfg_wdata,
    output int                       o_errors,
    output int                       o_pending
);
    import blc_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [TC_W-1:0]          tap_reg = TC_RESET;
    logic signed [DATA_W-1:0] dline    [TAPS] = '{default: '0};
    logic signed [DATA_W-1:0] coef_mem [TAPS] = '{default: '0};
    t_out                     conv_expected[$];

    function automatic int taps_in_use(input logic [TC_W-1:0] tc);
        int n;
        n = int'(tc);
        if (n < 1) n = 1;
        if (n > TAPS) n = TAPS;
        if (n > RES_CAP) n = RES_CAP;
        return n;
    endfunction

    function automatic void shift_in(input logic signed [DATA_W-1:0] x);
        int t;
        for (t = TAPS - 1; t > 0; t--) dline[t] = dline[t-1];
        dline[0] = x;
    endfunction

    function automatic logic signed [ACC_W-1:0] tap_sum(input int n);
        logic signed [ACC_W-1:0] acc;
        int t;
        acc = '0;
        for (t = 0; t < n; t++) acc = acc + coef_mem[t] * dline[t];
        return acc;
    endfunction

    task automatic predict_conv(input t_in it);
        int   n;
        int   k;
        t_out r;
        if (it.op == OP_LOAD) begin
            if (int'(it.coef_index) < TAPS) coef_mem[it.coef_index] = it.coef_value;
            return;
        end
        n = taps_in_use(tap_reg);
        shift_in(it.sample_value);
        r.conv_value = tap_sum(n);
        r.run_last   = it.block_end && (n == 1);
        conv_expected.push_back(r);
        if (it.block_end) begin
            // tail: zeros shifted in, then the line starts the next block silent
            for (k = 1; k < n; k++) begin
                shift_in('0);
                r.conv_value = tap_sum(n);
                r.run_last   = (k == n - 1);
                conv_expected.push_back(r);
            end
            foreach (dline[t]) dline[t] = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            tap_reg = TC_RESET;
            foreach (dline[t]) dline[t] = '0;
            conv_expected.delete();
        end else begin
            if (i_cfg_we) tap_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_conv(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (conv_expected.size() == 0) begin
                    if (o_errors < REPORT_MAX)
                        $display("%0t: unexpected result conv_value=%0d run_last=%0b",
                                 $realtime, i_out_data.conv_value, i_out_data.run_last);
                    o_errors++;
                end else begin
                    want = conv_expected.pop_front();
                    if (i_out_data.conv_value !== want.conv_value ||
                        i_out_data.run_last !== want.run_last) begin
                        if (o_errors < REPORT_MAX)
                            $display("%0t: conv_value exp %0d got %0d, run_last exp %0b got %0b",
                                     $realtime, want.conv_value, i_out_data.conv_value,
                                     want.run_last, i_out_data.run_last);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = conv_expected.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the block_linear_convolution testbench: clock, reset, sample and coefficient
// stimulus, tap count phases and the verdict. Depends on blc_pkg and conv_checker.
`timescale 1ns / 1ps

module tb_top;
    import blc_pkg::*;

    localparam int TAPS            = 32;
    localparam int SETTLE_CYCLES   = TAPS + 8;
    localparam int HOLD_CYCLES     = 600;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int PHASES          = 8;
    localparam logic [TC_W-1:0] TAP_PLAN [PHASES] =
        '{6'd1, 6'd0, 6'd63, 6'd2, 6'd24, 6'd33, 6'd7, 6'd32};

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic            o_stall;
    t_in             i_data      = '0;
    logic            o_valid;
    logic            i_stall     = 1'b0;
    t_out            o_data;
    logic            i_cfg_we    = 1'b0;
    logic [TC_W-1:0] i_cfg_wdata = '0;

    int   err_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;
    logic hold_req      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    block_linear_convolution #(.TAPS(TAPS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    conv_checker #(.TAPS(TAPS)) u_conv_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_in_data  (i_data),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out_data (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_errors   (err_count),
        .o_pending  (pending)
    );

    // result side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_q15();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic t_in make_sample(input logic signed [DATA_W-1:0] v, input logic last);
        t_in it;
        it.op           = OP_SAMPLE;
        it.sample_value = v;
        it.block_end    = last;
        it.coef_index   = IDX_W'($urandom);
        it.coef_value   = DATA_W'($urandom);
        return it;
    endfunction

    function automatic t_in make_load(input int idx, input logic signed [DATA_W-1:0] v);
        t_in it;
        it.op           = OP_LOAD;
        it.sample_value = DATA_W'($urandom);
        it.block_end    = 1'($urandom);
        it.coef_index   = IDX_W'(idx);
        it.coef_value   = v;
        return it;
    endfunction

    task automatic send_item(input t_in it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_taps(input logic [TC_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_items(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 15)
                send_item(make_load($urandom_range(0, TAPS - 1), pick_q15()));
            else
                send_item(make_sample(pick_q15(), $urandom_range(0, 5) == 0));
        end
    endtask

    initial begin
        int  i;
        int  p;
        t_in it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full coefficient store before any sample
        for (i = 0; i < TAPS; i++) send_item(make_load(i, 16'sh8000));

        // near full-scale sum, then a load carrying junk sample fields, then a block end
        for (i = 0; i < 20; i++) send_item(make_sample(16'sh8000, 1'b0));
        send_item(make_sample(16'sh7FFF, 1'b0));
        it = make_load(5, 16'sh7FFF);
        it.block_end    = 1'b1;
        it.sample_value = 16'sh8000;
        send_item(it);
        send_item(make_sample('0, 1'b0));
        send_item(make_sample(16'sh8000, 1'b1));

        for (p = 0; p < PHASES; p++) begin
            wait_results();
            write_taps(TAP_PLAN[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            if (p == 4) begin
                send_idle_pct = 0;
                hold_req      = 1'b1;
            end
            random_items(ITEMS_PER_PHASE);
        end
        wait_results();

        if (err_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/blc_pkg.sv
src/blc_ram.sv
src/blc_mac.sv
src/block_linear_convolution.sv
bench/conv_checker.sv
bench/tb_top.sv
